// File: rtl/svf_pkg.sv
// Shared constants and controller/datapath types for the state-variable lowpass filter.
package svf_pkg;

    localparam int CHANNELS   = 2;
    localparam int CHAN_W     = 1;
    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 24;
    localparam int STATE_W    = 32;
    localparam int CFG_ADDR_W = 1;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [CFG_ADDR_W-1:0] REG_CUTOFF  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DAMPING = 1'd1;

    localparam logic [COEF_W-1:0] CUTOFF_RST  = 24'd1287;
    localparam logic [COEF_W-1:0] DAMPING_RST = 24'd8099193;
    localparam logic [COEF_W-1:0] DAMP_ONE    = 24'd8388608;

    typedef enum logic [1:0] {
        MUL_DIFF_G,
        MUL_LO_D,
        MUL_HI_D,
        MUL_BP_G
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sum_en;
        logic     lo_en;
        logic     bp_en;
        logic     wr_state;
        logic     out_load;
    } svf_cmd_t;

    typedef struct packed {
        logic chan_ok;
    } svf_status_t;

endpackage

// File: rtl/svf_lowpass_filter.sv
// Top level of the trapezoidal state-variable lowpass filter.
//
//   Channel   Direction  Contents
//   s_        in         tdata: sample_in; tuser: chan
//   m_        out        tdata: lowpass_out; tuser: chan_out
//   cfg_      in         write enable, register index, 24-bit write data
//
// An item is accepted in ST_IDLE and steps through ST_M1, ST_SUM, ST_M2, ST_M3, ST_BP, ST_M4
// and ST_LP to ST_OUT, which loads its result into the output register once that is free;
// no new item is accepted before then. The steps come from the four products sharing one
// multiplier; the low-half product is registered, the other three are rounded and saturated.
// An out-of-range channel goes straight to ST_OUT, has its zero result loaded there and
// leaves the states alone. Reset clears the integrator states and loads the reset coefficients.
// A result waiting at the output does not stop the next item until it is finished.
module svf_lowpass_filter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [svf_pkg::SAMPLE_W-1:0]       s_tdata,  // [23:0] sample_in
    input  logic [svf_pkg::CHAN_W-1:0]         s_tuser,  // [0] chan
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [svf_pkg::SAMPLE_W-1:0]       m_tdata,  // [23:0] lowpass_out
    output logic [svf_pkg::CHAN_W-1:0]         m_tuser,  // [0] chan_out
    input  logic                               cfg_we,
    input  logic [svf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [svf_pkg::COEF_W-1:0]         cfg_wdata
);

    svf_pkg::svf_cmd_t    cmd;
    svf_pkg::svf_status_t status;

    svf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    svf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item was in progress");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten before its item was taken");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (m_tvalid && s_tready))
        else $error("result load did not raise valid and return to idle");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

// File: rtl/svf_mul.sv
// Shared signed multiplier with a registered product.
module svf_mul (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [svf_pkg::MUL_A_W-1:0]   a,
    input  logic signed [svf_pkg::MUL_B_W-1:0]   b,
    output logic signed [svf_pkg::MUL_P_W-1:0]   prod
);

    logic signed [svf_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// File: rtl/svf_ctrl.sv
// Controller state machine that sequences one item through the shared multiplier.
module svf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  svf_pkg::svf_status_t status,
    output svf_pkg::svf_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M1,
        ST_SUM,
        ST_M2,
        ST_M3,
        ST_BP,
        ST_M4,
        ST_LP,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = svf_pkg::MUL_DIFF_G;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = status.chan_ok ? ST_M1 : ST_OUT;
                end
            end
            ST_M1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = svf_pkg::MUL_DIFF_G;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_en = 1'b1;
                state_next = ST_M2;
            end
            ST_M2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = svf_pkg::MUL_LO_D;
                state_next  = ST_M3;
            end
            ST_M3: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = svf_pkg::MUL_HI_D;
                cmd.lo_en   = 1'b1;
                state_next  = ST_BP;
            end
            ST_BP: begin
                cmd.bp_en  = 1'b1;
                state_next = ST_M4;
            end
            ST_M4: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = svf_pkg::MUL_BP_G;
                state_next  = ST_LP;
            end
            ST_LP: begin
                cmd.wr_state = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_tvalid_next = cmd.out_load | (m_tvalid_reg & ~m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// File: rtl/svf_dp.sv
// Datapath with coefficient registers, integrator store, fixed-point arithmetic and output register.
module svf_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  svf_pkg::svf_cmd_t                    cmd,
    output svf_pkg::svf_status_t                 status,
    input  logic [svf_pkg::SAMPLE_W-1:0]         s_tdata,
    input  logic [svf_pkg::CHAN_W-1:0]           s_tuser,
    input  logic                                 cfg_we,
    input  logic [svf_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [svf_pkg::COEF_W-1:0]           cfg_wdata,
    output logic [svf_pkg::SAMPLE_W-1:0]         m_tdata,
    output logic [svf_pkg::CHAN_W-1:0]           m_tuser
);

    localparam int P_W = svf_pkg::MUL_P_W;

    function automatic logic signed [41:0] rnd16(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] t;
        t = p + P_W'(32768);
        return t[P_W-1:16];
    endfunction

    function automatic logic signed [39:0] sat40_43(input logic signed [42:0] v);
        if (&v[42:39] || ~|v[42:39]) begin
            return v[39:0];
        end
        return v[42] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    endfunction

    function automatic logic signed [31:0] sat32_41(input logic signed [40:0] v);
        if (&v[40:31] || ~|v[40:31]) begin
            return v[31:0];
        end
        return v[40] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    endfunction

    function automatic logic signed [31:0] sat32_34(input logic signed [33:0] v);
        if (&v[33:31] || ~|v[33:31]) begin
            return v[31:0];
        end
        return v[33] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    endfunction

    function automatic logic signed [31:0] sat32_44(input logic signed [43:0] v);
        if (&v[43:31] || ~|v[43:31]) begin
            return v[31:0];
        end
        return v[43] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    endfunction

    function automatic logic signed [23:0] sat24_43(input logic signed [42:0] v);
        if (&v[42:23] || ~|v[42:23]) begin
            return v[23:0];
        end
        return v[42] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
    endfunction

    logic [svf_pkg::COEF_W-1:0]           cutoff_reg;
    logic [svf_pkg::COEF_W-1:0]           damping_reg;
    logic [svf_pkg::COEF_W-1:0]           d_eff;
    logic signed [svf_pkg::STATE_W-1:0]   integ_one_reg [svf_pkg::CHANNELS];
    logic signed [svf_pkg::STATE_W-1:0]   integ_two_reg [svf_pkg::CHANNELS];

    logic [svf_pkg::CHAN_W-1:0]           chan_reg;
    logic signed [svf_pkg::SAMPLE_W-1:0]  x_reg;
    logic signed [svf_pkg::STATE_W-1:0]   s1_reg;
    logic signed [svf_pkg::STATE_W-1:0]   s2_reg;
    logic signed [39:0]                   sum_reg;
    logic signed [P_W-1:0]                lo_reg;
    logic signed [31:0]                   bp_reg;
    logic signed [svf_pkg::SAMPLE_W-1:0]  res_reg;
    logic [svf_pkg::SAMPLE_W-1:0]         m_data_reg;
    logic [svf_pkg::CHAN_W-1:0]           m_chan_reg;

    logic signed [svf_pkg::MUL_A_W-1:0]   mul_a;
    logic signed [svf_pkg::MUL_B_W-1:0]   mul_b;
    logic signed [P_W-1:0]                prod;

    logic signed [32:0]                   diff;
    logic signed [41:0]                   r16;
    logic signed [42:0]                   sum43;
    logic signed [63:0]                   acc;
    logic signed [63:0]                   acc_rnd;
    logic signed [33:0]                   s1_sum;
    logic signed [42:0]                   lp;
    logic signed [43:0]                   s2_sum;

    assign status.chan_ok = ({31'd0, s_tuser} < 32'(svf_pkg::CHANNELS));

    assign d_eff = (damping_reg > svf_pkg::DAMP_ONE) ? svf_pkg::DAMP_ONE : damping_reg;

    always_comb begin
        diff = {{9{x_reg[23]}}, x_reg} - {s2_reg[31], s2_reg};
        unique case (cmd.mul_sel)
            svf_pkg::MUL_DIFF_G: begin
                mul_a = diff;
                mul_b = {1'b0, cutoff_reg};
            end
            svf_pkg::MUL_LO_D: begin
                mul_a = {13'd0, sum_reg[19:0]};
                mul_b = {1'b0, d_eff};
            end
            svf_pkg::MUL_HI_D: begin
                mul_a = {{13{sum_reg[39]}}, sum_reg[39:20]};
                mul_b = {1'b0, d_eff};
            end
            svf_pkg::MUL_BP_G: begin
                mul_a = {bp_reg[31], bp_reg};
                mul_b = {1'b0, cutoff_reg};
            end
            default: begin
                mul_a = diff;
                mul_b = {1'b0, cutoff_reg};
            end
        endcase
    end

    svf_mul u_mul (
        .aclk (aclk),
        .en   (cmd.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb begin
        r16     = rnd16(prod);
        sum43   = {r16[41], r16} + {{11{s1_reg[31]}}, s1_reg};
        acc     = ({{6{prod[P_W-1]}}, prod} <<< 20) + {{6{lo_reg[P_W-1]}}, lo_reg};
        acc_rnd = acc + 64'sd4194304;
        s1_sum  = {bp_reg[31], bp_reg, 1'b0} - {{2{s1_reg[31]}}, s1_reg};
        lp      = {r16[41], r16} + {{11{s2_reg[31]}}, s2_reg};
        s2_sum  = {lp[42], lp} + {{2{r16[41]}}, r16};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg  <= svf_pkg::CUTOFF_RST;
            damping_reg <= svf_pkg::DAMPING_RST;
            for (int i = 0; i < svf_pkg::CHANNELS; i++) begin
                integ_one_reg[i] <= '0;
                integ_two_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    svf_pkg::REG_CUTOFF:  cutoff_reg  <= cfg_wdata;
                    svf_pkg::REG_DAMPING: damping_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (cmd.wr_state) begin
                integ_one_reg[chan_reg] <= sat32_34(s1_sum);
                integ_two_reg[chan_reg] <= sat32_44(s2_sum);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            chan_reg <= s_tuser;
            x_reg    <= s_tdata;
            s1_reg   <= integ_one_reg[s_tuser];
            s2_reg   <= integ_two_reg[s_tuser];
            res_reg  <= '0;
        end
        if (cmd.sum_en) begin
            sum_reg <= sat40_43(sum43);
        end
        if (cmd.lo_en) begin
            lo_reg <= prod;
        end
        if (cmd.bp_en) begin
            bp_reg <= sat32_41(acc_rnd[63:23]);
        end
        if (cmd.wr_state) begin
            res_reg <= sat24_43(lp);
        end
        if (cmd.out_load) begin
            m_data_reg <= res_reg;
            m_chan_reg <= chan_reg;
        end
    end

    assign m_tdata = m_data_reg;
    assign m_tuser = m_chan_reg;

endmodule
